@@ design/ramr_pkg.sv @@
// Package for the rational add/multiply/reduce core: payload structs and constants.
// No dependencies.
`timescale 1ns / 1ps
package ramr_pkg;
    localparam int OperandWidth = 32;
    localparam int WideWidth    = 64;
    localparam int CntWidth     = 7;

    localparam logic ActAdd = 1'b0;
    localparam logic ActMul = 1'b1;

    typedef struct packed {
        logic                         action;
        logic signed [31:0]           a_num;
        logic signed [31:0]           a_den;
        logic signed [31:0]           b_num;
        logic signed [31:0]           b_den;
    } t_in;

    typedef struct packed {
        logic signed [63:0]           res_num;
        logic signed [63:0]           res_den;
        logic signed [63:0]           whole_part;
        logic signed [63:0]           leftover;
        logic                         zero_den_error;
    } t_out;
endpackage

@@ design/ramr_divu.sv @@
// Bit-serial unsigned 64-bit divider, one quotient bit per cycle.
// Depends on ramr_pkg.
`timescale 1ns / 1ps
module ramr_divu (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ramr_pkg::WideWidth-1:0] i_dividend,
    input  logic [ramr_pkg::WideWidth-1:0] i_divisor,
    output logic                         o_done,
    output logic [ramr_pkg::WideWidth-1:0] o_quot,
    output logic [ramr_pkg::WideWidth-1:0] o_rem
);
    import ramr_pkg::*;

    logic                 r_busy, n_busy;
    logic [CntWidth-1:0]  r_cnt, n_cnt;
    logic [WideWidth-1:0] r_q, n_q;
    logic [WideWidth-1:0] r_r, n_r;
    logic [WideWidth-1:0] r_d;
    logic [WideWidth:0]   w_sh;
    logic [WideWidth:0]   w_sub;

    assign w_sh  = {r_r, r_q[WideWidth-1]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_r    = '0;
        end else if (r_busy) begin
            if (!w_sub[WideWidth]) begin
                n_r = w_sub[WideWidth-1:0];
                n_q = {r_q[WideWidth-2:0], 1'b1};
            end else begin
                n_r = w_sh[WideWidth-1:0];
                n_q = {r_q[WideWidth-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CntWidth'(WideWidth - 1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            o_done <= r_busy && !n_busy;
        end
        r_q <= n_q;
        r_r <= n_r;
        if (i_start) r_d <= i_divisor;
    end

    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

@@ design/ramr_mul.sv @@
// Shift-add 64x64 multiplier (low 64 bits), one multiplier bit per cycle.
// Depends on ramr_pkg.
`timescale 1ns / 1ps
module ramr_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ramr_pkg::WideWidth-1:0] i_a,
    input  logic [ramr_pkg::WideWidth-1:0] i_b,
    output logic                         o_done,
    output logic [ramr_pkg::WideWidth-1:0] o_p
);
    import ramr_pkg::*;

    logic                 r_busy;
    logic [CntWidth-1:0]  r_cnt;
    logic [WideWidth-1:0] r_a, r_b, r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntWidth'(WideWidth - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            if (r_b[0]) r_p <= r_p + r_a;
            r_a <= {r_a[WideWidth-2:0], 1'b0};
            r_b <= {1'b0, r_b[WideWidth-1:1]};
        end
    end

    assign o_p = r_p;
endmodule

@@ design/rational_add_multiply_reduce_core.sv @@
// Top level: sequencer for fraction reduce, add/multiply, gcd reduce and divide.
// Depends on ramr_pkg, ramr_divu, ramr_mul.
`timescale 1ns / 1ps
// One transaction at a time: busy is high from start until the result strobe.
// Divisions run through one shared bit-serial divider and products through
// one shift-add multiplier; the gcds are Euclid loops on the divider, so
// latency is data dependent and shortest for a zero-denominator error.
// The result is shown for one cycle with o_valid and cannot be held.
module rational_add_multiply_reduce_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  ramr_pkg::t_in   i_data,
    output logic            busy,
    output logic            o_valid,
    output ramr_pkg::t_out  o_data
);
    import ramr_pkg::*;

    localparam logic [3:0] StIdle   = 4'd0;
    localparam logic [3:0] StRedA   = 4'd1;
    localparam logic [3:0] StRedB   = 4'd2;
    localparam logic [3:0] StComb   = 4'd3;
    localparam logic [3:0] StRedR   = 4'd4;
    localparam logic [3:0] StGcd    = 4'd5;
    localparam logic [3:0] StDivN   = 4'd6;
    localparam logic [3:0] StDivD   = 4'd7;
    localparam logic [3:0] StMul    = 4'd8;
    localparam logic [3:0] StQuot   = 4'd9;
    localparam logic [3:0] StOut    = 4'd10;

    logic [3:0]           r_st;
    logic [3:0]           r_ret;
    logic [1:0]           r_step;
    logic                 r_act;
    logic [WideWidth-1:0] r_an, r_ad, r_bn, r_bd, r_rn, r_rd;
    logic [WideWidth-1:0] r_gx, r_gy;
    logic                 r_div_go, r_mul_go;
    logic [WideWidth-1:0] r_div_n, r_div_d, r_mul_a, r_mul_b;
    logic                 w_div_done, w_mul_done;
    logic [WideWidth-1:0] w_quot, w_rem, w_prod;
    logic [WideWidth-1:0] r_cur_n, r_cur_d;
    logic                 r_wait;

    ramr_divu u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_dividend(r_div_n), .i_divisor(r_div_d),
        .o_done(w_div_done), .o_quot(w_quot), .o_rem(w_rem)
    );

    ramr_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mul_go),
        .i_a(r_mul_a), .i_b(r_mul_b), .o_done(w_mul_done), .o_p(w_prod)
    );

    function automatic logic [WideWidth-1:0] f_abs(input logic [WideWidth-1:0] v);
        f_abs = v[WideWidth-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [WideWidth-1:0] f_sext(input logic [31:0] v);
        f_sext = {{(WideWidth-OperandWidth){v[OperandWidth-1]}}, v[OperandWidth-1:0]};
    endfunction

    function automatic logic [WideWidth-1:0] f_neg(input logic [WideWidth-1:0] v,
                                                    input logic s);
        f_neg = s ? (~v + 1'b1) : v;
    endfunction

    assign busy = (r_st != StIdle);

    // reduce of (r_cur_n, r_cur_d): StGcd (Euclid), StDivN, StDivD, then r_ret
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= StIdle;
            r_ret    <= StIdle;
            r_step   <= '0;
            r_div_go <= 1'b0;
            r_mul_go <= 1'b0;
            r_wait   <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            r_mul_go <= 1'b0;
            o_valid  <= 1'b0;
            unique case (r_st)
                StIdle: begin
                    if (start) begin
                        r_act <= i_data.action;
                        r_an  <= f_sext(i_data.a_num);
                        r_ad  <= f_sext(i_data.a_den);
                        r_bn  <= f_sext(i_data.b_num);
                        r_bd  <= f_sext(i_data.b_den);
                        if (f_sext(i_data.a_den) == '0 || f_sext(i_data.b_den) == '0) begin
                            o_data <= '{res_num: '0, res_den: '0, whole_part: '0,
                                        leftover: '0, zero_den_error: 1'b1};
                            r_st <= StOut;
                        end else begin
                            r_cur_n <= f_sext(i_data.a_num);
                            r_cur_d <= f_sext(i_data.a_den);
                            r_gx    <= f_abs(f_sext(i_data.a_num));
                            r_gy    <= f_abs(f_sext(i_data.a_den));
                            r_ret   <= StRedA;
                            r_wait  <= 1'b0;
                            r_st    <= StGcd;
                        end
                    end
                end
                StGcd: begin
                    if (!r_wait) begin
                        if (r_gy == '0) begin
                            r_div_n  <= f_abs(r_cur_n);
                            r_div_d  <= r_gx;
                            r_div_go <= 1'b1;
                            r_wait   <= 1'b1;
                            r_st     <= StDivN;
                        end else begin
                            r_div_n  <= r_gx;
                            r_div_d  <= r_gy;
                            r_div_go <= 1'b1;
                            r_wait   <= 1'b1;
                        end
                    end else if (w_div_done) begin
                        r_gx   <= r_gy;
                        r_gy   <= w_rem;
                        r_wait <= 1'b0;
                    end
                end
                StDivN: begin
                    if (w_div_done) begin
                        r_cur_n  <= f_neg(w_quot, r_cur_n[WideWidth-1]);
                        r_div_n  <= f_abs(r_cur_d);
                        r_div_d  <= r_gx;
                        r_div_go <= 1'b1;
                        r_st     <= StDivD;
                    end
                end
                StDivD: begin
                    if (w_div_done) begin
                        r_cur_d <= f_neg(w_quot, r_cur_d[WideWidth-1]);
                        r_st    <= r_ret;
                    end
                end
                StRedA: begin
                    r_an    <= r_cur_n;
                    r_ad    <= r_cur_d;
                    r_cur_n <= r_bn;
                    r_cur_d <= r_bd;
                    r_gx    <= f_abs(r_bn);
                    r_gy    <= f_abs(r_bd);
                    r_ret   <= StRedB;
                    r_wait  <= 1'b0;
                    r_st    <= StGcd;
                end
                StRedB: begin
                    r_bn   <= r_cur_n;
                    r_bd   <= r_cur_d;
                    r_step <= '0;
                    r_st   <= StComb;
                end
                StComb: begin
                    if (r_act == ActAdd && r_ad == r_bd) begin
                        r_rn <= r_an + r_bn;
                        r_rd <= r_ad;
                        r_st <= StRedR;
                    end else begin
                        // step 0: den product, 1: an*b?, 2: bn*ad
                        r_mul_go <= 1'b1;
                        r_mul_a  <= r_ad;
                        r_mul_b  <= r_bd;
                        r_st     <= StMul;
                    end
                end
                StMul: begin
                    if (w_mul_done) begin
                        unique case (r_step)
                            2'd0: begin
                                r_rd     <= w_prod;
                                r_mul_go <= 1'b1;
                                r_mul_a  <= r_an;
                                r_mul_b  <= (r_act == ActMul) ? r_bn : r_bd;
                                r_step   <= 2'd1;
                            end
                            2'd1: begin
                                r_rn <= w_prod;
                                if (r_act == ActMul) begin
                                    r_st <= StRedR;
                                end else begin
                                    r_mul_go <= 1'b1;
                                    r_mul_a  <= r_bn;
                                    r_mul_b  <= r_ad;
                                    r_step   <= 2'd2;
                                end
                            end
                            default: begin
                                r_rn <= r_rn + w_prod;
                                r_st <= StRedR;
                            end
                        endcase
                    end
                end
                StRedR: begin
                    r_cur_n <= r_rn;
                    r_cur_d <= r_rd;
                    r_gx    <= f_abs(r_rn);
                    r_gy    <= f_abs(r_rd);
                    r_ret   <= StQuot;
                    r_wait  <= 1'b0;
                    r_step  <= '0;
                    r_st    <= StGcd;
                end
                StQuot: begin
                    if (r_step == 2'd0) begin
                        r_div_n  <= f_abs(r_cur_n);
                        r_div_d  <= f_abs(r_cur_d);
                        r_div_go <= 1'b1;
                        r_step   <= 2'd1;
                    end else if (w_div_done) begin
                        o_data <= '{res_num: r_cur_n, res_den: r_cur_d,
                                    whole_part: f_neg(w_quot,
                                        r_cur_n[WideWidth-1] ^ r_cur_d[WideWidth-1]),
                                    leftover: f_neg(w_rem, r_cur_n[WideWidth-1]),
                                    zero_den_error: 1'b0};
                        r_st <= StOut;
                    end
                end
                StOut: begin
                    o_valid <= 1'b1;
                    r_st    <= StIdle;
                end
                default: r_st <= StIdle;
            endcase
        end
    end
endmodule
